>>> hdl/kdl_pkg.sv
// shared constants, types and codes of the keyed deque list
`default_nettype none

package kdl_pkg;

  // pool size and stored key width
  localparam int Capacity    = 64;
  localparam int KeyWidth    = 32;
  localparam int StoreWidth  = (KeyWidth < 32) ? KeyWidth : 32;
  localparam int StepWidth   = (Capacity > 1) ? $clog2(Capacity) : 1;

  // operation codes of an input beat
  localparam logic [2:0] KindInsert    = 3'd0;
  localparam logic [2:0] KindDeleteKey = 3'd1;
  localparam logic [2:0] KindPopFront  = 3'd2;
  localparam logic [2:0] KindPopBack   = 3'd3;
  localparam logic [2:0] KindDump      = 3'd4;

  // status codes of an output beat
  localparam logic [2:0] StatusDone     = 3'd0;
  localparam logic [2:0] StatusFull     = 3'd1;
  localparam logic [2:0] StatusNotFound = 3'd2;
  localparam logic [2:0] StatusEmpty    = 3'd3;
  localparam logic [2:0] StatusElement  = 3'd4;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CmdNop,
    CmdInsert,
    CmdPopFront,
    CmdPopBack,
    CmdRotate,
    CmdSearch
  } cmd_e;

  typedef logic [StoreWidth-1:0] skey_t;

  // one list slot as handed between neighbors
  typedef struct packed {
    logic  vld;
    skey_t key;
  } slot_t;

  // search token travelling along the chain
  typedef struct packed {
    logic tok;
    logic fnd;
  } tok_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] key;
  } kdl_in_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic [2:0]         status;
    logic               last;
  } kdl_out_t;

endpackage

`default_nettype wire

>>> hdl/kdl_cell.sv
// one list cell: holds one key slot and one stage of the search token path
`default_nettype none

module kdl_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  kdl_pkg::cmd_e          cmd_i,
  input  kdl_pkg::skey_t         skey_i,
  input  kdl_pkg::slot_t         left_slot_i,
  input  kdl_pkg::slot_t         right_slot_i,
  input  kdl_pkg::tok_t          left_tok_i,
  output kdl_pkg::slot_t         slot_o,
  output kdl_pkg::tok_t          tok_o
);

  logic           vld_q, vld_d;
  kdl_pkg::skey_t key_q, key_d;
  kdl_pkg::tok_t  tok_q;
  logic           hit;

  // match against the search key while the token sits here
  assign hit       = tok_q.tok & vld_q & (key_q == skey_i);
  assign tok_o.tok = tok_q.tok;
  assign tok_o.fnd = tok_q.fnd | hit;

  assign slot_o.vld = vld_q;
  assign slot_o.key = key_q;

  // slot update per broadcast command
  always_comb begin
    vld_d = vld_q;
    key_d = key_q;
    unique case (cmd_i)
      kdl_pkg::CmdInsert: begin
        vld_d = left_slot_i.vld;
        key_d = left_slot_i.key;
      end
      kdl_pkg::CmdPopFront, kdl_pkg::CmdRotate: begin
        vld_d = right_slot_i.vld;
        key_d = right_slot_i.key;
      end
      kdl_pkg::CmdPopBack: begin
        vld_d = vld_q & right_slot_i.vld;
      end
      kdl_pkg::CmdSearch: begin
        // from the first match on, every cell closes the gap
        if (tok_q.tok && tok_o.fnd) begin
          vld_d = right_slot_i.vld;
          key_d = right_slot_i.key;
        end
      end
      default: begin
      end
    endcase
  end

  // control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      vld_q <= vld_d;
      tok_q <= left_tok_i;
    end
  end

  // key payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

>>> hdl/keyed_deque_list_top.sv
// top level of the keyed deque list: cell chain, sequencer and output register
`default_nettype none

// Keyed deque list. The list lives in a chain of kdl_pkg::Capacity cells, front
// in cell 0, valid entries packed at the front; there is no clearing pass, reset
// empties the list at once. Delete by key sends a token down the chain, one
// cell per cycle, and the matching cell and all cells behind it shift left as
// it passes. Dump rotates the whole chain once around, one cell per cycle
// unless the output side stalls, emitting cell 0 when it is valid; an empty
// dump gives one beat. A new beat is taken once the previous operation is
// over and the output register is free or being emptied.
module keyed_deque_list_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  kdl_pkg::kdl_in_t  in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output kdl_pkg::kdl_out_t out_data_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StDump   = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [kdl_pkg::StepWidth-1:0] step_q, step_d;
  kdl_pkg::skey_t              skey_q, skey_d;
  logic                        out_vld_q, out_vld_d;
  kdl_pkg::kdl_out_t           out_q, out_d;
  logic                        load_out;
  logic                        out_free;
  logic                        accept;
  logic                        tok_start;
  kdl_pkg::cmd_e               cmd;

  kdl_pkg::slot_t slot   [kdl_pkg::Capacity];
  kdl_pkg::slot_t lslot  [kdl_pkg::Capacity];
  kdl_pkg::slot_t rslot  [kdl_pkg::Capacity];
  kdl_pkg::tok_t  tok    [kdl_pkg::Capacity];
  kdl_pkg::tok_t  ltok   [kdl_pkg::Capacity];
  kdl_pkg::slot_t in_slot;
  kdl_pkg::tok_t  start_tok;
  logic           dump_last;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign in_slot.vld   = 1'b1;
  assign in_slot.key   = in_data_i.key[kdl_pkg::StoreWidth-1:0];
  assign start_tok.tok = tok_start;
  assign start_tok.fnd = 1'b0;

  // neighbor wiring; the front wraps around to the tail only while rotating
  for (genvar i = 0; i < kdl_pkg::Capacity; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lslot[i] = in_slot;
      assign ltok[i]  = start_tok;
    end else begin : g_inner
      assign lslot[i] = slot[i-1];
      assign ltok[i]  = tok[i-1];
    end
    if (i == kdl_pkg::Capacity - 1) begin : g_last
      assign rslot[i] = (cmd == kdl_pkg::CmdRotate) ? slot[0] : '0;
    end else begin : g_mid
      assign rslot[i] = slot[i+1];
    end

    kdl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .skey_i      (skey_q),
      .left_slot_i (lslot[i]),
      .right_slot_i(rslot[i]),
      .left_tok_i  (ltok[i]),
      .slot_o      (slot[i]),
      .tok_o       (tok[i])
    );
  end

  // final element of a dump: next cell empty, or the last rotation step
  assign dump_last = !slot[1].vld ||
                     (step_q == kdl_pkg::StepWidth'(kdl_pkg::Capacity - 1));

  // sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    skey_d    = skey_q;
    cmd       = kdl_pkg::CmdNop;
    tok_start = 1'b0;
    load_out  = 1'b0;
    out_d     = '0;
    out_d.last = 1'b1;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (in_data_i.kind)
            kdl_pkg::KindInsert: begin
              load_out = 1'b1;
              if (slot[kdl_pkg::Capacity-1].vld) begin
                out_d.status = kdl_pkg::StatusFull;
              end else begin
                cmd          = kdl_pkg::CmdInsert;
                out_d.status = kdl_pkg::StatusDone;
              end
            end
            kdl_pkg::KindDeleteKey: begin
              skey_d    = in_data_i.key[kdl_pkg::StoreWidth-1:0];
              tok_start = 1'b1;
              state_d   = StSearch;
            end
            kdl_pkg::KindPopFront, kdl_pkg::KindPopBack: begin
              load_out = 1'b1;
              if (!slot[0].vld) begin
                out_d.status = kdl_pkg::StatusEmpty;
              end else begin
                cmd = (in_data_i.kind == kdl_pkg::KindPopFront) ?
                      kdl_pkg::CmdPopFront : kdl_pkg::CmdPopBack;
                out_d.status = kdl_pkg::StatusDone;
              end
            end
            kdl_pkg::KindDump: begin
              if (!slot[0].vld) begin
                load_out     = 1'b1;
                out_d.status = kdl_pkg::StatusEmpty;
              end else begin
                step_d  = '0;
                state_d = StDump;
              end
            end
            default: begin
              load_out     = 1'b1;
              out_d.status = kdl_pkg::StatusDone;
            end
          endcase
        end
      end
      StSearch: begin
        cmd = kdl_pkg::CmdSearch;
        // token leaves the tail cell this cycle
        if (tok[kdl_pkg::Capacity-1].tok) begin
          load_out     = 1'b1;
          out_d.status = tok[kdl_pkg::Capacity-1].fnd ?
                         kdl_pkg::StatusDone : kdl_pkg::StatusNotFound;
          state_d      = StIdle;
        end
      end
      StDump: begin
        // advance unless a valid front element waits for the output register
        if (!slot[0].vld || out_free) begin
          cmd = kdl_pkg::CmdRotate;
          if (slot[0].vld) begin
            load_out      = 1'b1;
            out_d.out_key = 32'(slot[0].key);
            out_d.status  = kdl_pkg::StatusElement;
            out_d.last    = dump_last;
          end
          if (step_q == kdl_pkg::StepWidth'(kdl_pkg::Capacity - 1)) begin
            state_d = StIdle;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    skey_q <= skey_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire
